// File: rtl/core/glyph_alpha_pixel_blender_assert.svh
// assertion macros for the glyph alpha pixel blender
`ifndef GLYPH_ALPHA_PIXEL_BLENDER_ASSERT_SVH
`define GLYPH_ALPHA_PIXEL_BLENDER_ASSERT_SVH

// property must hold on every clock edge outside reset
`define GAPB_ASSERT(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// condition must never be seen outside reset
`define GAPB_NEVER(label, clock, resetn, cond, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) !(cond)) else $error(msg);

`endif

// File: rtl/core/gapb_pkg.sv
// shared types, register codes and helpers for the glyph alpha pixel blender
package gapb_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ADDR_W = 22;
    localparam int SUM_W = 14;

    localparam logic [3:0] SOLID_THRESHOLD = 4'd3;
    localparam logic [3:0] COVERAGE_FULL = 4'hF;
    localparam logic [3:0] COVERAGE_NONE = 4'h0;
    localparam logic [SUM_W-1:0] ROUND_BIAS = 14'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_COLOR  = 3'd0,
        REG_SOLID_MODE  = 3'd1,
        REG_FB_WIDTH    = 3'd2,
        REG_FB_HEIGHT   = 3'd3,
        REG_CELL_WIDTH  = 3'd4,
        REG_CELL_HEIGHT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic [5:0]         cell_row;
        logic [5:0]         cell_col;
        logic [7:0]         coverage_byte;
        logic [15:0]        dest_pixel;
    } cmd_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] pixel_address;
        logic [15:0]       new_pixel;
    } result_t;

    typedef struct packed {
        logic [15:0] text_color;
        logic        solid_mode;
        logic [11:0] fb_width;
        logic [11:0] fb_height;
        logic [6:0]  cell_width;
        logic [6:0]  cell_height;
    } cfg_t;

    typedef struct packed {
        logic        we;
        logic        sel_color;
        logic [3:0]  a4;
        logic [11:0] xx;
        logic [11:0] yy;
        logic [15:0] dest;
    } clip_t;

    typedef struct packed {
        logic              we;
        logic              sel_color;
        logic [ADDR_W-1:0] row_base;
        logic [11:0]       xx;
        logic [SUM_W-1:0]  r_sum;
        logic [SUM_W-1:0]  g_sum;
        logic [SUM_W-1:0]  b_sum;
        logic [15:0]       dest;
    } mix_t;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    // exact floor(v / 255) for v below 16320
    function automatic logic [5:0] div255(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] t;
        t = v + 14'd1 + {8'd0, v[13:8]};
        return t[13:8];
    endfunction

endpackage

// File: rtl/core/gapb_clip.sv
// stage one: clipping, nibble select and write decision
module gapb_clip (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  gapb_pkg::cmd_t in_cmd,
    input  gapb_pkg::cfg_t cfg,
    output logic          out_valid,
    output gapb_pkg::clip_t out_data
);
    import gapb_pkg::*;

    logic        valid_reg;
    clip_t       data_reg;
    clip_t       data_next;
    logic signed [12:0] xx_s;
    logic signed [12:0] yy_s;
    logic        in_bounds;
    logic        odd_idx;
    logic [3:0]  a4;

    always_comb
    begin
        xx_s = 13'(in_cmd.origin_x) + $signed({7'd0, in_cmd.cell_col});
        yy_s = 13'(in_cmd.origin_y) + $signed({7'd0, in_cmd.cell_row});
        in_bounds = ({1'b0, in_cmd.cell_row} < cfg.cell_height)
                 && ({1'b0, in_cmd.cell_col} < cfg.cell_width)
                 && !xx_s[12] && (xx_s[11:0] < cfg.fb_width)
                 && !yy_s[12] && (yy_s[11:0] < cfg.fb_height);
        // parity of row * cell_width + col
        odd_idx = (in_cmd.cell_row[0] & cfg.cell_width[0]) ^ in_cmd.cell_col[0];
        a4 = odd_idx ? in_cmd.coverage_byte[3:0] : in_cmd.coverage_byte[7:4];
        data_next.we = in_bounds && (a4 != COVERAGE_NONE)
                    && !(cfg.solid_mode && (a4 < SOLID_THRESHOLD));
        data_next.sel_color = cfg.solid_mode || (a4 == COVERAGE_FULL);
        data_next.a4 = a4;
        data_next.xx = xx_s[11:0];
        data_next.yy = yy_s[11:0];
        data_next.dest = in_cmd.dest_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

// File: rtl/core/gapb_mix.sv
// stage two: row base product and per channel weighted sums
module gapb_mix (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  gapb_pkg::clip_t in_data,
    input  gapb_pkg::cfg_t  cfg,
    output logic           out_valid,
    output gapb_pkg::mix_t  out_data
);
    import gapb_pkg::*;

    logic        valid_reg;
    mix_t        data_reg;
    mix_t        data_next;
    logic [15:0] src;
    logic [15:0] dst;
    logic [7:0]  alpha;
    logic [7:0]  inv_alpha;
    logic [23:0] base_full;

    always_comb
    begin
        src = swap16(cfg.text_color);
        dst = swap16(in_data.dest);
        alpha = {in_data.a4, in_data.a4};
        inv_alpha = ~alpha;
        base_full = {12'd0, in_data.yy} * {12'd0, cfg.fb_width};
        data_next.we = in_data.we;
        data_next.sel_color = in_data.sel_color;
        data_next.row_base = base_full[ADDR_W-1:0];
        data_next.xx = in_data.xx;
        data_next.r_sum = {9'd0, src[15:11]} * {6'd0, alpha}
                        + {9'd0, dst[15:11]} * {6'd0, inv_alpha} + ROUND_BIAS;
        data_next.g_sum = {8'd0, src[10:5]} * {6'd0, alpha}
                        + {8'd0, dst[10:5]} * {6'd0, inv_alpha} + ROUND_BIAS;
        data_next.b_sum = {9'd0, src[4:0]} * {6'd0, alpha}
                        + {9'd0, dst[4:0]} * {6'd0, inv_alpha} + ROUND_BIAS;
        data_next.dest = in_data.dest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

// File: rtl/core/gapb_pack.sv
// stage three: divide by 255, repack pixel, finish address
module gapb_pack (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  gapb_pkg::mix_t     in_data,
    input  gapb_pkg::cfg_t     cfg,
    output logic              out_valid,
    output gapb_pkg::result_t  out_data
);
    import gapb_pkg::*;

    logic        valid_reg;
    result_t     data_reg;
    result_t     data_next;
    logic [5:0]  r_q;
    logic [5:0]  g_q;
    logic [5:0]  b_q;
    logic [15:0] blended;

    always_comb
    begin
        r_q = div255(in_data.r_sum);
        g_q = div255(in_data.g_sum);
        b_q = div255(in_data.b_sum);
        blended = swap16({r_q[4:0], g_q, b_q[4:0]});
        data_next.write_enable = in_data.we;
        if (in_data.we)
        begin
            data_next.pixel_address = in_data.row_base + {10'd0, in_data.xx};
            data_next.new_pixel = in_data.sel_color ? cfg.text_color : blended;
        end
        else
        begin
            data_next.pixel_address = '0;
            data_next.new_pixel = in_data.dest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

// File: rtl/core/glyph_alpha_pixel_blender.sv
// glyph alpha pixel blender: top level with configuration registers
//
// Takes one glyph pixel per clock and returns its framebuffer write through
// the clip, mix and pack registers: done pulses for one cycle with result
// holding write enable, address and new pixel. The three register stages
// (clip and nibble select, multiply, divide and repack) run every cycle, so
// busy stays low and a new item may follow each cycle. The receiver cannot
// stall: a result is shown for exactly one cycle. Configuration writes are
// always ready and should be issued only with no item in flight.
module glyph_alpha_pixel_blender (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  gapb_pkg::cmd_t                      cmd,
    output logic                               done,
    output gapb_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gapb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gapb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gapb_pkg::*;

    cfg_t  cfg_reg;
    logic  accept;
    logic  clip_valid;
    clip_t clip_data;
    logic  mix_valid;
    mix_t  mix_data;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_color  <= 16'hFFFF;
            cfg_reg.solid_mode  <= 1'b0;
            cfg_reg.fb_width    <= 12'd800;
            cfg_reg.fb_height   <= 12'd480;
            cfg_reg.cell_width  <= 7'd30;
            cfg_reg.cell_height <= 7'd30;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TEXT_COLOR:  cfg_reg.text_color  <= cfg_data;
                REG_SOLID_MODE:  cfg_reg.solid_mode  <= cfg_data[0];
                REG_FB_WIDTH:    cfg_reg.fb_width    <= cfg_data[11:0];
                REG_FB_HEIGHT:   cfg_reg.fb_height   <= cfg_data[11:0];
                REG_CELL_WIDTH:  cfg_reg.cell_width  <= cfg_data[6:0];
                REG_CELL_HEIGHT: cfg_reg.cell_height <= cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    gapb_clip u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_cmd    (cmd),
        .cfg       (cfg_reg),
        .out_valid (clip_valid),
        .out_data  (clip_data)
    );

    gapb_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (clip_valid),
        .in_data   (clip_data),
        .cfg       (cfg_reg),
        .out_valid (mix_valid),
        .out_data  (mix_data)
    );

    gapb_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_data   (mix_data),
        .cfg       (cfg_reg),
        .out_valid (done),
        .out_data  (result)
    );

endmodule

// File: rtl/core/gapb_checker.sv
// port level checks for the glyph alpha pixel blender
`include "glyph_alpha_pixel_blender_assert.svh"

module gapb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input gapb_pkg::result_t  result
);
    import gapb_pkg::*;

    `GAPB_ASSERT(a_done_follows_item, clk, rst_n, (start && !busy) |-> ##3 done, "item without result")
    `GAPB_ASSERT(a_no_spurious_done, clk, rst_n, done |-> $past(start && !busy, 3), "result without item")
    `GAPB_NEVER(a_idle_addr_zero, clk, rst_n, done && !result.write_enable && (result.pixel_address != '0), "address set on skipped write")
    `GAPB_NEVER(a_never_busy, clk, rst_n, busy, "pipeline refused an item")

endmodule

bind glyph_alpha_pixel_blender gapb_checker u_gapb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
